@@ hdl/qbcbc_pkg.sv @@
// ---------------------------------------------------------------------------
// qbcbc_pkg: shared types and constants of the quadratic box corner check
// Opcodes, register indexes, controller states, datapath commands and the
// command and status bundles that join the controller and the datapath.
// ---------------------------------------------------------------------------
package qbcbc_pkg;

    localparam int NUM_VARS  = 8;
    localparam int MAX_TERMS = 64;
    localparam int VAR_W     = $clog2(NUM_VARS);
    localparam int TERM_W    = $clog2(MAX_TERMS);
    localparam int PAIR_W    = 2 * VAR_W;
    localparam int PAIRS     = NUM_VARS * NUM_VARS;
    localparam int VALUE_W   = 64;

    typedef enum logic [1:0] {
        OP_VAR   = 2'd0,
        OP_TERM  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_GRID   = 1'b0,
        CFG_THRESH = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_C1, S_C2, S_V1, S_V2, S_V3, S_TRD,
        S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
        S_BCHK, S_FOD, S_WSEL, S_WJ, S_WDRAIN, S_WUPD, S_WCHK, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD_VAR, DP_LOAD_TERM, DP_START, DP_C1, DP_C2,
        DP_V1, DP_V2, DP_V3, DP_TRD, DP_T1, DP_T2, DP_T3, DP_T4, DP_T5, DP_T6,
        DP_FOD, DP_WSEL, DP_WJ, DP_WDRAIN, DP_WUPD, DP_WNEXT, DP_FAIL, DP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic term_none;
        logic term_last;
        logic value_hi;
        logic no_active;
        logic ord_last;
        logic out_free;
    } t_status;

endpackage

@@ hdl/qbcbc_ctrl.sv @@
// ---------------------------------------------------------------------------
// qbcbc_ctrl: sequencer of the corner check
// Takes input words, then walks constant, variable, term, delta and corner
// phases by issuing one datapath command per cycle.
// ---------------------------------------------------------------------------
module qbcbc_ctrl
    import qbcbc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic [1:0] i_op,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && t_op'(i_op) == OP_START) n_state = S_C1;
            end
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_V1;
            S_V1:   n_state = S_V2;
            S_V2:   n_state = S_V3;
            S_V3: begin
                if (!i_status.idx_last) n_state = S_V1;
                else if (i_status.term_none) n_state = S_BCHK;
                else n_state = S_TRD;
            end
            S_TRD:  n_state = S_T1;
            S_T1:   n_state = S_T2;
            S_T2:   n_state = S_T3;
            S_T3:   n_state = S_T4;
            S_T4:   n_state = S_T5;
            S_T5:   n_state = S_T6;
            S_T6:   n_state = i_status.term_last ? S_BCHK : S_TRD;
            S_BCHK: begin
                if (i_status.value_hi || i_status.no_active) n_state = S_DONE;
                else n_state = S_FOD;
            end
            S_FOD:    n_state = i_status.idx_last ? S_WSEL : S_FOD;
            S_WSEL:   n_state = S_WJ;
            S_WJ:     n_state = i_status.idx_last ? S_WDRAIN : S_WJ;
            S_WDRAIN: n_state = S_WUPD;
            S_WUPD:   n_state = S_WCHK;
            S_WCHK: begin
                if (i_status.value_hi || i_status.ord_last) n_state = S_DONE;
                else n_state = S_WSEL;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.op = DP_NOP;
        o_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (t_op'(i_op))
                        OP_VAR:   o_cmd.op = DP_LOAD_VAR;
                        OP_TERM:  o_cmd.op = DP_LOAD_TERM;
                        OP_START: o_cmd.op = DP_START;
                        default:  o_cmd.op = DP_NOP;
                    endcase
                end
            end
            S_C1:     o_cmd.op = DP_C1;
            S_C2:     o_cmd.op = DP_C2;
            S_V1:     o_cmd.op = DP_V1;
            S_V2:     o_cmd.op = DP_V2;
            S_V3:     o_cmd.op = DP_V3;
            S_TRD:    o_cmd.op = DP_TRD;
            S_T1:     o_cmd.op = DP_T1;
            S_T2:     o_cmd.op = DP_T2;
            S_T3:     o_cmd.op = DP_T3;
            S_T4:     o_cmd.op = DP_T4;
            S_T5:     o_cmd.op = DP_T5;
            S_T6:     o_cmd.op = DP_T6;
            S_BCHK:   o_cmd.op = i_status.value_hi ? DP_FAIL : DP_NOP;
            S_FOD:    o_cmd.op = DP_FOD;
            S_WSEL:   o_cmd.op = DP_WSEL;
            S_WJ:     o_cmd.op = DP_WJ;
            S_WDRAIN: o_cmd.op = DP_WDRAIN;
            S_WUPD:   o_cmd.op = DP_WUPD;
            S_WCHK: begin
                if (i_status.value_hi) o_cmd.op = DP_FAIL;
                else if (i_status.ord_last) o_cmd.op = DP_NOP;
                else o_cmd.op = DP_WNEXT;
            end
            S_DONE:   o_cmd.op = i_status.out_free ? DP_PUBLISH : DP_NOP;
            default:  o_cmd.op = DP_NOP;
        endcase
    end

endmodule

@@ hdl/qbcbc_dp.sv @@
// ---------------------------------------------------------------------------
// qbcbc_dp: datapath of the corner check
// Variable and term stores, one shared 64x11 multiplier, running value,
// per-variable deltas, pair interaction memory and the result register.
// ---------------------------------------------------------------------------
module qbcbc_dp
    import qbcbc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic [2:0]    i_var_index,
    input  logic [31:0]   i_linear_coeff,
    input  logic [9:0]    i_lower_bound,
    input  logic [9:0]    i_upper_bound,
    input  logic [2:0]    i_term_left,
    input  logic [2:0]    i_term_right,
    input  logic [31:0]   i_term_coeff,
    input  logic [31:0]   i_cut_constant,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_covered,
    output logic [8:0]    o_corner_count
);

    // configuration
    logic [9:0]          r_grid;
    logic [VALUE_W-1:0]  r_thresh;

    // variable and term stores
    logic [31:0]         r_coeff [NUM_VARS];
    logic [9:0]          r_low   [NUM_VARS];
    logic [9:0]          r_high  [NUM_VARS];
    logic [37:0]         r_term_mem [MAX_TERMS];
    logic [37:0]         r_term_q;
    logic [TERM_W:0]     r_tcnt;
    logic [NUM_VARS-1:0] r_tused;

    // evaluation state
    logic [31:0]         r_const;
    logic [VALUE_W-1:0]  r_prod;
    logic [VALUE_W-1:0]  r_value;
    logic [VALUE_W-1:0]  r_d [NUM_VARS];
    logic [VALUE_W-1:0]  r_inter_mem [PAIRS];
    logic [VALUE_W-1:0]  r_inter_q;
    logic [PAIRS-1:0]    r_ivalid;
    logic [NUM_VARS-1:0] r_act;
    logic [VAR_W:0]      r_cnt;
    logic [VAR_W-1:0]    r_p2v [NUM_VARS];
    logic [VAR_W-1:0]    r_idx;
    logic [TERM_W-1:0]   r_tix;
    logic [NUM_VARS-1:0] r_ord;
    logic [VAR_W-1:0]    r_kv;
    logic [VALUE_W-1:0]  r_adj;
    logic                r_hit;
    logic [NUM_VARS-1:0] r_sel;
    logic [8:0]          r_insp;
    logic                r_ok;

    // result register
    logic                r_out_valid;
    logic                r_out_cov;
    logic [8:0]          r_out_insp;

    // term fields
    logic [31:0]         t_c;
    logic [VAR_W-1:0]    t_l;
    logic [VAR_W-1:0]    t_r;
    logic [10:0]         dh [NUM_VARS];

    logic [VALUE_W-1:0]  mul_a;
    logic [10:0]         mul_b;
    logic [VALUE_W-1:0]  mul_b_ext;
    logic [VALUE_W-1:0]  mul_p;

    logic [NUM_VARS-1:0] act_now;
    logic [VAR_W-1:0]    p2v_now [NUM_VARS];
    logic [VAR_W:0]      cnt_now;
    logic [VAR_W-1:0]    kpos;
    logic [PAIR_W-1:0]   term_pair;
    logic [PAIR_W-1:0]   walk_pair;
    logic                out_free;

    function automatic logic [VALUE_W-1:0] sext32(input logic [31:0] x);
        return {{(VALUE_W-32){x[31]}}, x};
    endfunction

    function automatic logic [PAIR_W-1:0] pair_addr(input logic [VAR_W-1:0] a,
                                                    input logic [VAR_W-1:0] b);
        return (a < b) ? {a, b} : {b, a};
    endfunction

    assign t_c = r_term_q[31:0];
    assign t_l = r_term_q[32 +: VAR_W];
    assign t_r = r_term_q[35 +: VAR_W];

    // bound differences, negative when bounds are inverted
    always_comb begin
        for (int i = 0; i < NUM_VARS; i++) begin
            dh[i] = {1'b0, r_high[i]} - {1'b0, r_low[i]};
        end
    end

    // active variables and their position list
    always_comb begin
        cnt_now = '0;
        for (int i = 0; i < NUM_VARS; i++) begin
            p2v_now[i] = '0;
        end
        for (int i = 0; i < NUM_VARS; i++) begin
            act_now[i] = ((r_coeff[i] != '0) || r_tused[i]) && (r_low[i] != r_high[i]);
            if (act_now[i]) begin
                p2v_now[cnt_now[VAR_W-1:0]] = VAR_W'(i);
                cnt_now = cnt_now + 1'b1;
            end
        end
    end

    // lowest set bit of the corner ordinal picks the flipped position
    always_comb begin
        kpos = '0;
        for (int i = NUM_VARS - 1; i >= 0; i--) begin
            if (r_ord[i]) kpos = VAR_W'(i);
        end
    end

    assign term_pair = pair_addr(t_l, t_r);
    assign walk_pair = pair_addr(r_kv, r_idx);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            DP_C1:  begin mul_a = sext32(r_const);        mul_b = {1'b0, r_grid}; end
            DP_C2:  begin mul_a = r_prod;                 mul_b = {1'b0, r_grid}; end
            DP_V1:  begin mul_a = sext32(r_coeff[r_idx]); mul_b = {1'b0, r_grid}; end
            DP_V2:  begin mul_a = r_prod;                 mul_b = {1'b0, r_low[r_idx]}; end
            DP_T1:  begin mul_a = sext32(t_c);            mul_b = {1'b0, r_low[t_l]}; end
            DP_T2:  begin mul_a = r_prod;                 mul_b = {1'b0, r_low[t_r]}; end
            DP_T3:  begin mul_a = sext32(t_c);            mul_b = {1'b0, r_low[t_r]}; end
            DP_T4:  begin mul_a = sext32(t_c);            mul_b = dh[t_l]; end
            DP_T5:  begin mul_a = r_prod;                 mul_b = dh[t_r]; end
            DP_FOD: begin mul_a = r_d[r_idx];             mul_b = dh[r_idx]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_b_ext = {{(VALUE_W-11){mul_b[10]}}, mul_b};
    assign mul_p     = VALUE_W'(mul_a * mul_b_ext);
    assign out_free  = !r_out_valid || !i_stall;

    // status back to the controller
    always_comb begin
        o_status.idx_last  = (r_idx == VAR_W'(NUM_VARS - 1));
        o_status.term_none = (r_tcnt == '0);
        o_status.term_last = ({1'b0, r_tix} == r_tcnt - 1'b1);
        o_status.value_hi  = ($signed(r_value) > $signed(r_thresh));
        o_status.no_active = (r_cnt == '0);
        o_status.ord_last  = (r_ord == NUM_VARS'(((NUM_VARS + 1)'(1) << r_cnt) - 1'b1));
        o_status.out_free  = out_free;
    end

    // term store: one write at load, registered read during the term pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LOAD_TERM && i_term_left != i_term_right
            && r_tcnt < (TERM_W + 1)'(MAX_TERMS)) begin
            r_term_mem[r_tcnt[TERM_W-1:0]] <= {i_term_right, i_term_left, i_term_coeff};
        end
        if (i_cmd.op == DP_TRD) begin
            r_term_q <= r_term_mem[r_tix];
        end
    end

    // pair interaction memory: written in the term pass, read in the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_T6 && r_act[t_l] && r_act[t_r]) begin
            r_inter_mem[term_pair] <= r_prod;
        end
        if (i_cmd.op == DP_WJ) begin
            r_inter_q <= r_inter_mem[walk_pair];
        end
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid      <= 10'd1;
            r_thresh    <= '0;
            r_tcnt      <= '0;
            r_tused     <= '0;
            r_ivalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GRID:   r_grid   <= i_cfg_data[9:0];
                    CFG_THRESH: r_thresh <= i_cfg_data;
                    default:    r_grid   <= r_grid;
                endcase
            end
            if (i_cmd.op == DP_LOAD_TERM && i_term_left != i_term_right
                && r_tcnt < (TERM_W + 1)'(MAX_TERMS)) begin
                r_tcnt  <= r_tcnt + 1'b1;
                r_tused <= r_tused | (NUM_VARS'(1) << i_term_left)
                                   | (NUM_VARS'(1) << i_term_right);
            end
            if (i_cmd.op == DP_START) begin
                r_ivalid <= '0;
            end
            if (i_cmd.op == DP_T6 && r_act[t_l] && r_act[t_r]) begin
                r_ivalid[term_pair] <= 1'b1;
            end
            // publish a new word, or drop the one just taken
            if (i_cmd.op == DP_PUBLISH) begin
                r_out_valid <= 1'b1;
                r_tcnt      <= '0;
                r_tused     <= '0;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload datapath
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD_VAR: begin
                r_coeff[i_var_index] <= i_linear_coeff;
                r_low[i_var_index]   <= i_lower_bound;
                r_high[i_var_index]  <= i_upper_bound;
            end
            DP_START: begin
                r_act  <= act_now;
                r_cnt  <= cnt_now;
                r_p2v  <= p2v_now;
                r_idx  <= '0;
                r_tix  <= '0;
                r_ord  <= NUM_VARS'(1);
                r_sel  <= '0;
                r_insp <= 9'd1;
                r_ok   <= 1'b1;
            end
            DP_C1: r_prod <= mul_p;
            DP_C2: r_value <= mul_p;
            DP_V1: r_prod <= mul_p;
            DP_V2: begin
                r_d[r_idx] <= r_prod;
                r_prod     <= mul_p;
            end
            DP_V3: begin
                r_value <= r_value + r_prod;
                r_idx   <= r_idx + 1'b1;
            end
            DP_T1: r_prod <= mul_p;
            DP_T2: begin
                r_d[t_r] <= r_d[t_r] + r_prod;
                r_prod   <= mul_p;
            end
            DP_T3: begin
                r_value <= r_value + r_prod;
                r_prod  <= mul_p;
            end
            DP_T4: begin
                r_d[t_l] <= r_d[t_l] + r_prod;
                r_prod   <= mul_p;
            end
            DP_T5: r_prod <= mul_p;
            DP_T6: r_tix <= r_tix + 1'b1;
            DP_FOD: begin
                r_d[r_idx] <= mul_p;
                r_idx      <= r_idx + 1'b1;
            end
            DP_WSEL: begin
                r_kv  <= r_p2v[kpos];
                r_adj <= r_d[r_p2v[kpos]];
                r_idx <= '0;
                r_hit <= 1'b0;
            end
            DP_WJ: begin
                if (r_hit) r_adj <= r_adj + r_inter_q;
                r_hit <= (r_idx != r_kv) && r_sel[r_idx] && r_ivalid[walk_pair];
                r_idx <= r_idx + 1'b1;
            end
            DP_WDRAIN: begin
                if (r_hit) r_adj <= r_adj + r_inter_q;
                r_hit <= 1'b0;
            end
            DP_WUPD: begin
                if (r_sel[r_kv]) r_value <= r_value - r_adj;
                else r_value <= r_value + r_adj;
                r_sel[r_kv] <= ~r_sel[r_kv];
                r_insp      <= r_insp + 1'b1;
            end
            DP_WNEXT: r_ord <= r_ord + 1'b1;
            DP_FAIL:  r_ok  <= 1'b0;
            DP_PUBLISH: begin
                r_out_cov  <= r_ok;
                r_out_insp <= r_insp;
            end
            default: r_const <= r_const;
        endcase
        if (i_cmd.op == DP_START) begin
            r_const <= i_cut_constant;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_covered      = r_out_cov;
    assign o_corner_count = r_out_insp;

endmodule

@@ hdl/quadratic_box_corner_bound_check_core.sv @@
// ---------------------------------------------------------------------------
// quadratic_box_corner_bound_check_core: corner bound check of a quadratic
// Loads variables and pair terms, then on a start word checks box corners
// against the threshold until one exceeds it and reports one result word.
// ---------------------------------------------------------------------------
//   channel  | handshake          | word
//   input    | i_valid / o_stall  | op, variable, term or constant fields
//   output   | o_valid / i_stall  | covered, corner count
//   config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Load words are accepted back to back while the core is idle. A start word
// runs the value and delta setup, then the first order deltas and the
// corner walk, paced by the single shared multiplier and the one-read port
// of the pair memory. Reset is synchronous, active low, and needs no
// clearing pass. A pending result in the output register does not block
// loads; the next start finishes only once that result has been taken.
// ---------------------------------------------------------------------------
module quadratic_box_corner_bound_check_core
    import qbcbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_var_index,
    input  logic [31:0] i_linear_coeff,
    input  logic [9:0]  i_lower_bound,
    input  logic [9:0]  i_upper_bound,
    input  logic [2:0]  i_term_left,
    input  logic [2:0]  i_term_right,
    input  logic [31:0] i_term_coeff,
    input  logic [31:0] i_cut_constant,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_covered,
    output logic [8:0]  o_corner_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    qbcbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic and storage
    qbcbc_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_var_index         (i_var_index),
        .i_linear_coeff      (i_linear_coeff),
        .i_lower_bound       (i_lower_bound),
        .i_upper_bound       (i_upper_bound),
        .i_term_left         (i_term_left),
        .i_term_right        (i_term_right),
        .i_term_coeff        (i_term_coeff),
        .i_cut_constant      (i_cut_constant),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_covered           (o_covered),
        .o_corner_count      (o_corner_count)
    );

endmodule

@@ hdl/qbcbc_checker.sv @@
// ---------------------------------------------------------------------------
// qbcbc_checker: port-level checks of the corner bound check core
// Watches the top level ports for result, busy and reset behavior.
// ---------------------------------------------------------------------------
module qbcbc_checker
    import qbcbc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_op,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_covered,
    input logic [8:0] o_corner_count
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_covered)
                               && $stable(o_corner_count))
        else $error("result word changed while stalled");

    // every result counts at least the low corner
    a_insp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_corner_count != 9'd0)
        else $error("result with zero corners inspected");

    // an accepted start word makes the core busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_op == OP_START |=> o_stall)
        else $error("core not busy after start word");

    // an accepted load word leaves the core ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_VAR || i_op == OP_TERM) |=> !o_stall)
        else $error("core busy after load word");

    // reset empties the output and leaves the core ready
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or busy left set by reset");

endmodule

bind quadratic_box_corner_bound_check_core qbcbc_checker u_qbcbc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_stall             (o_stall),
    .i_op                (i_op),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_covered           (o_covered),
    .o_corner_count      (o_corner_count)
);

@@ test/tb_quadratic_box_corner_bound_check_core.sv @@
// ---------------------------------------------------------------------------
// tb_quadratic_box_corner_bound_check_core: self-checking bench of the core
// Drives load and start words with random gaps, stalls the result side at
// random, predicts every result word and compares it field by field.
// ---------------------------------------------------------------------------
module tb_quadratic_box_corner_bound_check_core;
    import qbcbc_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    typedef struct {
        t_op         op;
        logic [2:0]  var_index;
        logic [31:0] linear_coeff;
        logic [9:0]  lower_bound;
        logic [9:0]  upper_bound;
        logic [2:0]  term_left;
        logic [2:0]  term_right;
        logic [31:0] term_coeff;
        logic [31:0] cut_constant;
    } t_word;

    typedef struct {
        logic       covered;
        logic [8:0] corners;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_op;
    logic [2:0]  i_var_index;
    logic [31:0] i_linear_coeff;
    logic [9:0]  i_lower_bound;
    logic [9:0]  i_upper_bound;
    logic [2:0]  i_term_left;
    logic [2:0]  i_term_right;
    logic [31:0] i_term_coeff;
    logic [31:0] i_cut_constant;
    logic        o_valid;
    logic        i_stall;
    logic        o_covered;
    logic [8:0]  o_corner_count;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    // shadow of the block state
    logic [63:0] sh_coeff [NUM_VARS];
    logic [9:0]  sh_low [NUM_VARS];
    logic [9:0]  sh_high [NUM_VARS];
    logic [31:0] sh_term_coeff [MAX_TERMS];
    logic [2:0]  sh_term_left [MAX_TERMS];
    logic [2:0]  sh_term_right [MAX_TERMS];
    int          sh_term_count;
    logic [9:0]  sh_grid;
    logic [63:0] sh_thresh;

    t_verdict    pending_verdicts [$];
    int          errors;
    int          words_sent;
    int          cycles;
    bit          no_idle;
    int          rx_wait;
    int          rx_hold;

    quadratic_box_corner_bound_check_core dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] sext(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic bit over_limit(logic [63:0] v);
        return $signed(v) > $signed(sh_thresh);
    endfunction

    // evaluate the low corner, then walk the remaining corners in Gray order
    function automatic t_verdict corner_check(logic [31:0] cst);
        bit          used [NUM_VARS];
        int          pos [NUM_VARS];
        int          act [NUM_VARS];
        logic [63:0] fod [NUM_VARS];
        logic [63:0] idel [NUM_VARS][NUM_VARS];
        logic [63:0] q, acc, d, w, adj, c, dl, dr;
        logic [7:0]  sel;
        int          cnt, inspected, gray, prev, k, ord, l, r, v;
        bit          ok;
        t_verdict    res;
        q = {54'd0, sh_grid};
        cnt = 0;
        inspected = 1;
        ok = 1'b1;
        for (int i = 0; i < NUM_VARS; i++) begin
            used[i] = sh_coeff[i] != 0;
            pos[i] = -1;
            for (int j = 0; j < NUM_VARS; j++) idel[i][j] = '0;
        end
        for (int t = 0; t < sh_term_count; t++) begin
            used[sh_term_left[t]] = 1'b1;
            used[sh_term_right[t]] = 1'b1;
        end
        for (int i = 0; i < NUM_VARS; i++) begin
            if (used[i] && sh_low[i] != sh_high[i]) begin
                pos[i] = cnt;
                act[cnt] = i;
                cnt++;
            end
        end
        acc = sext(cst) * q * q;
        for (int i = 0; i < NUM_VARS; i++) acc += sh_coeff[i] * q * {54'd0, sh_low[i]};
        for (int t = 0; t < sh_term_count; t++) begin
            acc += sext(sh_term_coeff[t]) * {54'd0, sh_low[sh_term_left[t]]}
                   * {54'd0, sh_low[sh_term_right[t]]};
        end
        if (over_limit(acc)) begin
            ok = 1'b0;
        end else if (cnt > 0) begin
            for (int i = 0; i < cnt; i++) begin
                v = act[i];
                d = sh_coeff[v] * q;
                for (int t = 0; t < sh_term_count; t++) begin
                    c = sext(sh_term_coeff[t]);
                    if (sh_term_left[t] == v) d += c * {54'd0, sh_low[sh_term_right[t]]};
                    else if (sh_term_right[t] == v) d += c * {54'd0, sh_low[sh_term_left[t]]};
                end
                fod[i] = ({54'd0, sh_high[v]} - {54'd0, sh_low[v]}) * d;
            end
            // last term naming a pair wins
            for (int t = 0; t < sh_term_count; t++) begin
                l = sh_term_left[t];
                r = sh_term_right[t];
                if (pos[l] >= 0 && pos[r] >= 0) begin
                    dl = {54'd0, sh_high[l]} - {54'd0, sh_low[l]};
                    dr = {54'd0, sh_high[r]} - {54'd0, sh_low[r]};
                    w = sext(sh_term_coeff[t]) * dl * dr;
                    idel[pos[l]][pos[r]] = w;
                    idel[pos[r]][pos[l]] = w;
                end
            end
            sel = '0;
            prev = 0;
            for (ord = 1; ord < (1 << cnt); ord++) begin
                gray = ord ^ (ord >> 1);
                k = 0;
                while (!(((gray ^ prev) >> k) & 1)) k++;
                adj = fod[k];
                for (int j = 0; j < cnt; j++) if (j != k && sel[j]) adj += idel[k][j];
                if (sel[k]) acc -= adj;
                else acc += adj;
                sel[k] = ~sel[k];
                inspected++;
                if (over_limit(acc)) begin
                    ok = 1'b0;
                    break;
                end
                prev = gray;
            end
        end
        res.covered = ok;
        res.corners = inspected[8:0];
        return res;
    endfunction

    // update the shadow state on an accepted word
    task automatic absorb_word(t_word w);
        t_verdict vd;
        case (w.op)
            OP_VAR: begin
                sh_coeff[w.var_index] = sext(w.linear_coeff);
                sh_low[w.var_index] = w.lower_bound;
                sh_high[w.var_index] = w.upper_bound;
            end
            OP_TERM: begin
                if (w.term_left != w.term_right && sh_term_count < MAX_TERMS) begin
                    sh_term_coeff[sh_term_count] = w.term_coeff;
                    sh_term_left[sh_term_count] = w.term_left;
                    sh_term_right[sh_term_count] = w.term_right;
                    sh_term_count++;
                end
            end
            OP_START: begin
                vd = corner_check(w.cut_constant);
                pending_verdicts.insert(pending_verdicts.size(), vd);
                sh_term_count = 0;
            end
            default: ;
        endcase
    endtask

    // offer one word, hold it until accepted
    task automatic send_word(t_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op = w.op;
        i_var_index = w.var_index;
        i_linear_coeff = w.linear_coeff;
        i_lower_bound = w.lower_bound;
        i_upper_bound = w.upper_bound;
        i_term_left = w.term_left;
        i_term_right = w.term_right;
        i_term_coeff = w.term_coeff;
        i_cut_constant = w.cut_constant;
        i_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        absorb_word(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_word blank_word(t_op op);
        t_word w;
        w.op = op;
        w.var_index = 3'($urandom);
        w.linear_coeff = $urandom;
        w.lower_bound = 10'($urandom);
        w.upper_bound = 10'($urandom);
        w.term_left = 3'($urandom);
        w.term_right = 3'($urandom);
        w.term_coeff = $urandom;
        w.cut_constant = $urandom;
        return w;
    endfunction

    task automatic load_var(int idx, logic [31:0] coeff, int lo, int hi);
        t_word w;
        w = blank_word(OP_VAR);
        w.var_index = 3'(idx);
        w.linear_coeff = coeff;
        w.lower_bound = 10'(lo);
        w.upper_bound = 10'(hi);
        send_word(w);
    endtask

    task automatic load_term(int l, int r, logic [31:0] coeff);
        t_word w;
        w = blank_word(OP_TERM);
        w.term_left = 3'(l);
        w.term_right = 3'(r);
        w.term_coeff = coeff;
        send_word(w);
    endtask

    task automatic start_check(logic [31:0] cst);
        t_word w;
        w = blank_word(OP_START);
        w.cut_constant = cst;
        send_word(w);
    endtask

    // drain results, then let trailing load words settle before idle work
    task automatic settle();
        i_valid = 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_GRID) sh_grid = data[9:0];
        else sh_thresh = data;
    endtask

    // one random problem: reload every variable, up to five terms or now and then 60 to 70, then start
    task automatic random_problem(int spread_max);
        int spread, n_terms, idx;
        logic [31:0] coeff;
        int lo;
        spread = $urandom_range(0, spread_max);
        for (int i = 0; i < NUM_VARS; i++) begin
            idx = (i + spread) % NUM_VARS;
            coeff = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
            lo = $urandom_range(0, 1000);
            load_var(idx, coeff, lo, (i < spread) ? $urandom_range(0, 1000) : lo);
        end
        n_terms = ($urandom_range(0, 20) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
        for (int t = 0; t < n_terms; t++) begin
            if ($urandom_range(0, 15) == 0) send_word(blank_word(OP_NONE));
            load_term($urandom_range(0, 7), $urandom_range(0, 7), $urandom);
        end
        start_check($urandom);
    endtask

    // all variables flat and zero, walk of a single corner
    task automatic test_defaults();
        for (int i = 0; i < NUM_VARS; i++) load_var(i, 32'd0, 5, 5);
        start_check(32'd0);
        start_check(32'd1);
        start_check(32'hFFFF_FFFF);
        settle();
    endtask

    // field extremes, duplicate pair, degenerate term, inverted bounds, op 3
    task automatic test_directed();
        write_reg(CFG_GRID, 64'd1000);
        write_reg(CFG_THRESH, 64'h7FFF_FFFF_FFFF_FFFF);
        load_var(0, 32'h7FFF_FFFF, 0, 1000);
        load_var(1, 32'h8000_0000, 1000, 0);
        load_var(2, 32'd3, 1023, 512);
        load_term(0, 1, 32'h7FFF_FFFF);
        load_term(1, 0, 32'h8000_0000);
        load_term(2, 2, 32'd77);
        load_term(7, 0, 32'd5);
        send_word(blank_word(OP_NONE));
        start_check(32'h7FFF_FFFF);
        start_check(32'h8000_0000);
        settle();
        write_reg(CFG_THRESH, 64'h8000_0000_0000_0000);
        start_check(32'h8000_0000);
        settle();
        write_reg(CFG_GRID, 64'd1);
        write_reg(CFG_THRESH, 64'd0);
        // fill the term store beyond capacity
        for (int t = 0; t < MAX_TERMS + 2; t++) load_term(t % 7, 7, 32'hFFFF_FFFF);
        start_check(32'd0);
        settle();
    endtask

    task automatic test_random();
        logic [63:0] thr [4];
        logic [9:0]  grd [4];
        thr = '{64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd0, 64'd0};
        grd = '{10'd1, 10'd1000, 10'd1, 10'd1};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_GRID, ph < 4 ? 64'(grd[ph]) : 64'($urandom_range(1, 1000)));
            write_reg(CFG_THRESH, ph < 4 && ph != 3 ? thr[ph] : {$urandom, $urandom});
            no_idle = (ph == 2);
            while (words_sent < 100 * (ph + 1)) random_problem($urandom_range(0, 12) == 0 ? 8 : 4);
            settle();
        end
        no_idle = 1'b0;
    endtask

    // hold the result side for a long stretch while words keep coming
    task automatic test_backpressure();
        write_reg(CFG_THRESH, 64'h7FFF_FFFF_FFFF_FFFF);
        rx_hold = 3000;
        repeat (3) random_problem(2);
        settle();
    endtask

    // result side: stall driver
    initial begin
        i_stall = 1'b0;
        rx_wait = 0;
        rx_hold = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall = 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // result side: compare each accepted word with the oldest prediction
    initial begin
        t_verdict exp_v;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                rx_wait = no_idle ? 0 : $urandom_range(0, 6);
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result covered=%0d corners=%0d",
                             $time, o_covered, o_corner_count);
                    errors++;
                end else begin
                    exp_v = pending_verdicts.pop_front();
                    if (o_covered !== exp_v.covered) begin
                        $display("%0t: covered expected %0d actual %0d",
                                 $time, exp_v.covered, o_covered);
                        errors++;
                    end
                    if (o_corner_count !== exp_v.corners) begin
                        $display("%0t: corner count expected %0d actual %0d",
                                 $time, exp_v.corners, o_corner_count);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        errors = 0;
        words_sent = 0;
        no_idle = 1'b0;
        sh_grid = 10'd1;
        sh_thresh = '0;
        sh_term_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_NONE;
        i_var_index = '0;
        i_linear_coeff = '0;
        i_lower_bound = '0;
        i_upper_bound = '0;
        i_term_left = '0;
        i_term_right = '0;
        i_term_coeff = '0;
        i_cut_constant = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_GRID;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_defaults();
        test_directed();
        test_random();
        test_backpressure();
        repeat (100) @(negedge i_clk);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
